// ===== rtl/smcore_pkg.sv =====
package smcore_pkg;

   localparam int ADDR_BITS_DEFAULT = 16;

   typedef enum logic [1:0] {
      REQ_EXEC  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_READ  = 2'd2,
      REQ_SETPC = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] address;
      logic [7:0]  write_byte;
   } req_type;

   typedef struct packed {
      logic [15:0] prog_counter;
      logic [15:0] stack_ptr;
      logic [7:0]  reg_acc;
      logic [7:0]  reg_flags;
      logic [7:0]  reg_bee;
      logic [7:0]  reg_cee;
      logic [7:0]  reg_high;
      logic [7:0]  reg_low;
      logic        irq_master_enable;
      logic [4:0]  cycles_taken;
      logic [7:0]  read_byte;
      logic        unimplemented;
   } rsp_type;

   // Sequencer states. Each memory read has a request state and a data state;
   // each store is done in a single state.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,   // issue read at PC for opcode
      ST_DECODE,  // opcode available
      ST_OPR1,    // issue read of first operand byte
      ST_OPR1_D,
      ST_OPR2,
      ST_OPR2_D,
      ST_MEM,     // data access (load or store)
      ST_MEM_D,
      ST_PUSH2,   // second store of a two-byte write
      ST_HOSTRD,
      ST_DONE
   } state_type;

   // Shared unit operations.
   typedef enum logic [2:0] {
      ALU_PASS,
      ALU_ADD16,
      ALU_INC8,
      ALU_DEC8,
      ALU_CP8
   } alu_op_type;

   // Opcodes in the subset.
   localparam logic [7:0] OP_NOP  = 8'h00, OP_LDBC = 8'h01, OP_STBC = 8'h02,
                          OP_INCBC= 8'h03, OP_INCB = 8'h04, OP_DECB = 8'h05,
                          OP_LDB  = 8'h06, OP_RLCA = 8'h07, OP_STSP = 8'h08,
                          OP_ADDHL= 8'h09, OP_LDABC= 8'h0A, OP_DECBC= 8'h0B,
                          OP_INCC = 8'h0C, OP_DECC = 8'h0D, OP_LDC  = 8'h0E,
                          OP_RRCA = 8'h0F, OP_JR   = 8'h18, OP_JRNZ = 8'h20,
                          OP_LDHL = 8'h21, OP_JRZ  = 8'h28, OP_STHLD= 8'h32,
                          OP_LDA  = 8'h3E, OP_MOVBA= 8'h47, OP_MOVLA= 8'h6F,
                          OP_XORA = 8'hAF, OP_JP   = 8'hC3, OP_CB   = 8'hCB,
                          OP_CALL = 8'hCD, OP_STH  = 8'hE0, OP_STA16= 8'hEA,
                          OP_LDH  = 8'hF0, OP_DI   = 8'hF3, OP_LDA16= 8'hFA,
                          OP_CP   = 8'hFE, CB_RES0A= 8'h87;

endpackage

// ===== rtl/sm83_instruction_subset_core.sv =====
// Channel | Direction | Ports
// request | in        | req_valid, req_stall, req_data (req_type)
// result  | out       | rsp_valid, rsp_stall, rsp_data (rsp_type)
// One request is taken at a time. Host writes and PC sets go straight to finish; host
// reads pass a read and a data state first. An instruction passes fetch, decode and
// finish, request and data states per operand byte or load, one per single-port store.
// The result waits in an output register; the next request is taken as it is sent.
// Reset is synchronous; memory contents are not cleared.
module sm83_instruction_subset_core
   import smcore_pkg::*;
#(
   parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [7:0] mem [DEPTH];

   state_type   state_ff, state_in;
   logic [15:0] pc_ff, pc_in, sp_ff, sp_in;
   logic [7:0]  a_ff, a_in, f_ff, f_in, b_ff, b_in, c_ff, c_in, h_ff, h_in, l_ff, l_in;
   logic        ime_ff, ime_in;
   logic [7:0]  op_ff, op_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [1:0]  kind_ff, kind_in;
   logic [15:0] haddr_ff, haddr_in;
   logic [7:0]  hbyte_ff, hbyte_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   // Memory port controls.
   logic [15:0] maddr;
   logic        mwe;
   logic [7:0]  mwdata, mrdata_ff;

   // Shared 16-bit unit.
   alu_op_type  alu_op;
   logic [15:0] alu_a, alu_b;
   logic [16:0] alu_sum;
   logic [7:0]  alu_flags;
   logic [4:0]  cyc;
   logic        bad, finish;

   logic accept;
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Single-port memory with registered read data.
   always_ff @(posedge clock) begin
      if (mwe) begin
         mem[maddr[ADDR_BITS-1:0]] <= mwdata;
      end
      mrdata_ff <= mem[maddr[ADDR_BITS-1:0]];
   end

   // Shared arithmetic unit.
   always_comb begin
      alu_sum   = {1'b0, alu_a} + {1'b0, alu_b};
      alu_flags = f_ff & 8'hF0;
      unique case (alu_op)
         ALU_PASS: ;
         ALU_ADD16: begin
            alu_flags = {f_ff[7], 1'b0,
                         ({1'b0, alu_a[11:0]} + {1'b0, alu_b[11:0]}) > 13'h0FFF,
                         alu_sum[16], 4'h0};
         end
         ALU_INC8: begin
            alu_flags = {alu_sum[7:0] == 8'h00, 1'b0, alu_a[3:0] == 4'hF, f_ff[4], 4'h0};
         end
         ALU_DEC8: begin
            alu_flags = {alu_sum[7:0] == 8'h00, 1'b1, alu_a[3:0] == 4'h0, f_ff[4], 4'h0};
         end
         ALU_CP8: begin
            alu_flags = {alu_a[7:0] == alu_b[7:0], 1'b1, alu_a[3:0] < alu_b[3:0],
                         alu_a[7:0] < alu_b[7:0], 4'h0};
         end
         default: ;
      endcase
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_kind_type'(req_data.req_type))
                  REQ_EXEC:  state_in = ST_FETCH;
                  REQ_READ:  state_in = ST_HOSTRD;
                  REQ_WRITE, REQ_SETPC: state_in = ST_DONE;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_FETCH:  state_in = ST_DECODE;
         ST_DECODE: begin
            unique case (op_in)
               OP_STBC, OP_LDABC, OP_STHLD: state_in = ST_MEM;
               OP_LDBC, OP_LDB, OP_STSP, OP_LDC, OP_JR, OP_LDHL, OP_LDA,
               OP_JP, OP_CB, OP_CALL, OP_STH, OP_STA16, OP_LDH, OP_LDA16,
               OP_CP: state_in = ST_OPR1;
               // A branch not taken skips its offset byte and finishes.
               OP_JRNZ: state_in = f_ff[7] ? ST_DONE : ST_OPR1;
               OP_JRZ:  state_in = f_ff[7] ? ST_OPR1 : ST_DONE;
               default: state_in = ST_DONE;
            endcase
         end
         ST_OPR1:   state_in = ST_OPR1_D;
         ST_OPR1_D: begin
            unique case (op_ff)
               OP_LDBC, OP_STSP, OP_LDHL, OP_JP, OP_CALL, OP_STA16, OP_LDA16:
                  state_in = ST_OPR2;
               OP_STH, OP_LDH: state_in = ST_MEM;
               default: state_in = ST_DONE;
            endcase
         end
         ST_OPR2:   state_in = ST_OPR2_D;
         ST_OPR2_D: begin
            unique case (op_ff)
               OP_STSP, OP_CALL, OP_STA16, OP_LDA16: state_in = ST_MEM;
               default: state_in = ST_DONE;
            endcase
         end
         ST_MEM: begin
            unique case (op_ff)
               OP_LDABC, OP_LDH, OP_LDA16: state_in = ST_MEM_D;
               OP_STSP, OP_CALL: state_in = ST_PUSH2;
               default: state_in = ST_DONE;
            endcase
         end
         ST_MEM_D:  state_in = ST_DONE;
         ST_PUSH2:  state_in = ST_DONE;
         ST_HOSTRD: state_in = ST_MEM_D;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      pc_in = pc_ff; sp_in = sp_ff; a_in = a_ff; f_in = f_ff; b_in = b_ff;
      c_in = c_ff; h_in = h_ff; l_in = l_ff; ime_in = ime_ff;
      op_in = op_ff; lo_in = lo_ff; hi_in = hi_ff;
      kind_in = kind_ff; haddr_in = haddr_ff; hbyte_in = hbyte_ff;
      maddr = pc_ff; mwe = 1'b0; mwdata = a_ff;
      alu_op = ALU_PASS; alu_a = 16'h0000; alu_b = 16'h0000;
      cyc = 5'd0; bad = 1'b0; finish = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in  = req_data.req_type;
               haddr_in = req_data.address;
               hbyte_in = req_data.write_byte;
            end
         end
         ST_FETCH: begin
            maddr = pc_ff;
            pc_in = pc_ff + 16'd1;
         end
         ST_DECODE: begin
            op_in = mrdata_ff;
            unique case (mrdata_ff)
               OP_INCB:  begin alu_op = ALU_INC8; alu_a = {8'h00, b_ff}; alu_b = 16'h0001;
                            b_in = alu_sum[7:0]; f_in = alu_flags; end
               OP_DECB:  begin alu_op = ALU_DEC8; alu_a = {8'h00, b_ff}; alu_b = 16'hFFFF;
                            b_in = alu_sum[7:0]; f_in = alu_flags; end
               OP_INCC:  begin alu_op = ALU_INC8; alu_a = {8'h00, c_ff}; alu_b = 16'h0001;
                            c_in = alu_sum[7:0]; f_in = alu_flags; end
               OP_DECC:  begin alu_op = ALU_DEC8; alu_a = {8'h00, c_ff}; alu_b = 16'hFFFF;
                            c_in = alu_sum[7:0]; f_in = alu_flags; end
               OP_INCBC: begin alu_a = {b_ff, c_ff}; alu_b = 16'h0001;
                            {b_in, c_in} = alu_sum[15:0]; end
               OP_DECBC: begin alu_a = {b_ff, c_ff}; alu_b = 16'hFFFF;
                            {b_in, c_in} = alu_sum[15:0]; end
               OP_ADDHL: begin alu_op = ALU_ADD16; alu_a = {h_ff, l_ff}; alu_b = {b_ff, c_ff};
                            {h_in, l_in} = alu_sum[15:0]; f_in = alu_flags; end
               OP_RLCA:  begin a_in = {a_ff[6:0], a_ff[7]}; f_in = {3'b000, a_ff[7], 4'h0}; end
               OP_RRCA:  begin a_in = {a_ff[0], a_ff[7:1]}; f_in = {3'b000, a_ff[0], 4'h0}; end
               OP_MOVBA: b_in = a_ff;
               OP_MOVLA: l_in = a_ff;
               OP_XORA:  begin a_in = 8'h00; f_in = 8'h80; end
               OP_DI:    ime_in = 1'b0;
               OP_JRNZ:  if (f_ff[7]) pc_in = pc_ff + 16'd1;
               OP_JRZ:   if (!f_ff[7]) pc_in = pc_ff + 16'd1;
               OP_NOP, OP_STBC, OP_LDABC, OP_STHLD, OP_LDBC, OP_LDB, OP_STSP, OP_LDC,
               OP_JR, OP_LDHL, OP_LDA, OP_JP, OP_CB, OP_CALL, OP_STH, OP_STA16, OP_LDH,
               OP_LDA16, OP_CP: ;
               default: ;
            endcase
         end
         ST_OPR1: begin
            maddr = pc_ff;
            pc_in = pc_ff + 16'd1;
         end
         ST_OPR1_D: begin
            lo_in = mrdata_ff;
            unique case (op_ff)
               OP_LDB: b_in = mrdata_ff;
               OP_LDC: c_in = mrdata_ff;
               OP_LDA: a_in = mrdata_ff;
               OP_JR, OP_JRNZ, OP_JRZ: begin
                  alu_a = pc_ff; alu_b = {{8{mrdata_ff[7]}}, mrdata_ff};
                  pc_in = alu_sum[15:0];
               end
               OP_CP: begin
                  alu_op = ALU_CP8; alu_a = {8'h00, a_ff}; alu_b = {8'h00, mrdata_ff};
                  f_in = alu_flags;
               end
               OP_CB: if (mrdata_ff == CB_RES0A) a_in = {a_ff[7:1], 1'b0};
               default: ;
            endcase
         end
         ST_OPR2: begin
            maddr = pc_ff;
            pc_in = pc_ff + 16'd1;
         end
         ST_OPR2_D: begin
            hi_in = mrdata_ff;
            unique case (op_ff)
               OP_LDBC: {b_in, c_in} = {mrdata_ff, lo_ff};
               OP_LDHL: {h_in, l_in} = {mrdata_ff, lo_ff};
               OP_JP:   pc_in = {mrdata_ff, lo_ff};
               OP_CALL: begin alu_a = sp_ff; alu_b = 16'hFFFF; sp_in = alu_sum[15:0]; end
               default: ;
            endcase
         end
         ST_MEM: begin
            unique case (op_ff)
               OP_STBC:  begin maddr = {b_ff, c_ff}; mwe = 1'b1; end
               OP_LDABC: maddr = {b_ff, c_ff};
               OP_STHLD: begin
                  maddr = {h_ff, l_ff}; mwe = 1'b1;
                  alu_a = {h_ff, l_ff}; alu_b = 16'hFFFF; {h_in, l_in} = alu_sum[15:0];
               end
               OP_STH:   begin maddr = {8'hFF, lo_ff}; mwe = 1'b1; end
               OP_LDH:   maddr = {8'hFF, lo_ff};
               OP_STA16: begin maddr = {hi_ff, lo_ff}; mwe = 1'b1; end
               OP_LDA16: maddr = {hi_ff, lo_ff};
               OP_STSP:  begin maddr = {hi_ff, lo_ff}; mwe = 1'b1; mwdata = sp_ff[7:0]; end
               OP_CALL:  begin
                  maddr = sp_ff; mwe = 1'b1; mwdata = pc_ff[15:8];
                  alu_a = sp_ff; alu_b = 16'hFFFF; sp_in = alu_sum[15:0];
               end
               default: ;
            endcase
         end
         ST_PUSH2: begin
            mwe = 1'b1;
            if (op_ff == OP_CALL) begin
               maddr = sp_ff; mwdata = pc_ff[7:0]; pc_in = {hi_ff, lo_ff};
            end else begin
               alu_a = {hi_ff, lo_ff}; alu_b = 16'h0001;
               maddr = alu_sum[15:0]; mwdata = sp_ff[15:8];
            end
         end
         ST_HOSTRD: maddr = haddr_ff;
         ST_MEM_D: begin
            if (kind_ff == REQ_EXEC) a_in = mrdata_ff;
            else                     hbyte_in = mrdata_ff;
         end
         ST_DONE: begin
            finish = 1'b1;
            unique case (req_kind_type'(kind_ff))
               REQ_WRITE: begin maddr = haddr_ff; mwe = 1'b1; mwdata = hbyte_ff; end
               REQ_SETPC: pc_in = haddr_ff;
               REQ_READ, REQ_EXEC: ;
               default: ;
            endcase
            if (kind_ff == REQ_EXEC) begin
               unique case (op_ff)
                  OP_NOP, OP_INCB, OP_DECB, OP_RLCA, OP_INCC, OP_DECC, OP_RRCA,
                  OP_MOVBA, OP_MOVLA, OP_XORA, OP_DI: cyc = 5'd4;
                  OP_STBC, OP_INCBC, OP_LDB, OP_ADDHL, OP_LDABC, OP_DECBC, OP_LDC,
                  OP_STHLD, OP_LDA, OP_CP: cyc = 5'd8;
                  OP_LDBC, OP_JR, OP_LDHL, OP_STH, OP_LDH: cyc = 5'd12;
                  OP_JRNZ: cyc = f_ff[7] ? 5'd8 : 5'd12;
                  OP_JRZ:  cyc = f_ff[7] ? 5'd12 : 5'd8;
                  OP_JP, OP_STA16, OP_LDA16: cyc = 5'd16;
                  OP_STSP: cyc = 5'd20;
                  OP_CALL: cyc = 5'd24;
                  OP_CB: begin
                     if (lo_ff == CB_RES0A) cyc = 5'd8;
                     else                   bad = 1'b1;
                  end
                  default: bad = 1'b1;
               endcase
            end
            rsp_valid_in = 1'b1;
            rsp_in = '{prog_counter: pc_in, stack_ptr: sp_ff, reg_acc: a_ff,
                       reg_flags: f_ff & 8'hF0, reg_bee: b_ff, reg_cee: c_ff,
                       reg_high: h_ff, reg_low: l_ff, irq_master_enable: ime_ff,
                       cycles_taken: cyc,
                       read_byte: (kind_ff == REQ_READ) ? hbyte_ff : 8'h00,
                       unimplemented: bad};
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff <= 16'h0100; sp_ff <= 16'hFFFE;
         a_ff <= 8'h00; f_ff <= 8'h00; b_ff <= 8'h00; c_ff <= 8'h00;
         h_ff <= 8'h00; l_ff <= 8'h00; ime_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in; sp_ff <= sp_in;
         a_ff <= a_in; f_ff <= f_in; b_ff <= b_in; c_ff <= c_in;
         h_ff <= h_in; l_ff <= l_in; ime_ff <= ime_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff <= op_in; lo_ff <= lo_in; hi_ff <= hi_in;
      kind_ff <= kind_in; haddr_ff <= haddr_in; hbyte_ff <= hbyte_in;
      rsp_ff <= rsp_in;
   end

   // The core is busy only after taking a request.
   a_busy_from_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !accept) |=> state_ff == ST_IDLE)
      else $error("sequencer left idle without a request");

   // A result is produced only at the end of a request.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside the final step");

   // No new request while a result is stuck.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !accept)
      else $error("request taken while result held");

   // Unimplemented opcodes are charged no cycles.
   a_bad_zero_cyc: assert property (@(posedge clock) disable iff (reset)
      (finish && bad) |-> cyc == 5'd0)
      else $error("cycles charged for unimplemented opcode");

endmodule

// ===== test/tb_sm83_instruction_subset_core.sv =====
module tb_sm83_instruction_subset_core;
   import smcore_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   sm83_instruction_subset_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Shadow copy of the core state.
   logic [7:0]  mem_img [0:65535];
   bit          mem_set [0:65535];
   logic [15:0] wr_list [$];
   logic [15:0] pc_q;
   logic [15:0] sp_q;
   logic [7:0]  ra, rf, rb, rc, rh, rl;
   logic        ime;

   rsp_type     pending_rsp [$];
   int unsigned mismatch_cnt;
   int unsigned items_sent;
   int unsigned send_pct;
   int unsigned recv_pct;

   typedef struct {
      req_type r;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic [7:0] op_list [0:33] = '{
      OP_NOP, OP_LDBC, OP_STBC, OP_INCBC, OP_INCB, OP_DECB, OP_LDB, OP_RLCA, OP_STSP,
      OP_ADDHL, OP_LDABC, OP_DECBC, OP_INCC, OP_DECC, OP_LDC, OP_RRCA, OP_JR, OP_JRNZ,
      OP_LDHL, OP_JRZ, OP_STHLD, OP_LDA, OP_MOVBA, OP_MOVLA, OP_XORA, OP_JP, OP_CB,
      OP_CALL, OP_STH, OP_STA16, OP_LDH, OP_DI, OP_LDA16, OP_CP
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void mem_put(logic [15:0] a, logic [7:0] v);
      if (!mem_set[a]) wr_list.push_back(a);
      mem_set[a] = 1'b1;
      mem_img[a] = v;
   endfunction

   function automatic logic [7:0] fetch_b();
      logic [7:0] v;
      v = mem_img[pc_q];
      pc_q = pc_q + 16'd1;
      return v;
   endfunction

   function automatic logic [15:0] fetch_w();
      logic [7:0] lo;
      logic [7:0] hi;
      lo = fetch_b();
      hi = fetch_b();
      return {hi, lo};
   endfunction

   function automatic void jump_rel();
      logic [7:0] off;
      off = fetch_b();
      pc_q = pc_q + {{8{off[7]}}, off};
   endfunction

   function automatic logic [7:0] inc_flags(logic [7:0] v);
      rf = rf & 8'h10;
      if (v == 8'hFF) rf = rf | 8'h80;
      if (v[3:0] == 4'hF) rf = rf | 8'h20;
      return v + 8'd1;
   endfunction

   function automatic logic [7:0] dec_flags(logic [7:0] v);
      rf = (rf & 8'h10) | 8'h40;
      if (v == 8'h01) rf = rf | 8'h80;
      if (v[3:0] == 4'h0) rf = rf | 8'h20;
      return v - 8'd1;
   endfunction

   // Advances the shadow state by one transaction and returns the result it causes.
   function automatic rsp_type core_step(req_type r);
      rsp_type     o;
      logic [7:0]  op, v, b;
      logic [15:0] a16;
      logic [16:0] sum;
      logic [12:0] half;
      logic [4:0]  cyc;
      logic        bad;
      logic [7:0]  rd;
      cyc = 5'd0;
      bad = 1'b0;
      rd  = 8'h00;
      case (req_kind_type'(r.req_type))
         REQ_EXEC: begin
            op = fetch_b();
            case (op)
               OP_NOP:   cyc = 5'd4;
               OP_LDBC:  begin {rb, rc} = fetch_w(); cyc = 5'd12; end
               OP_STBC:  begin mem_put({rb, rc}, ra); cyc = 5'd8; end
               OP_INCBC: begin {rb, rc} = {rb, rc} + 16'd1; cyc = 5'd8; end
               OP_INCB:  begin rb = inc_flags(rb); cyc = 5'd4; end
               OP_DECB:  begin rb = dec_flags(rb); cyc = 5'd4; end
               OP_LDB:   begin rb = fetch_b(); cyc = 5'd8; end
               OP_RLCA: begin
                  rf = ra[7] ? 8'h10 : 8'h00;
                  ra = {ra[6:0], ra[7]};
                  cyc = 5'd4;
               end
               OP_STSP: begin
                  a16 = fetch_w();
                  mem_put(a16, sp_q[7:0]);
                  mem_put(a16 + 16'd1, sp_q[15:8]);
                  cyc = 5'd20;
               end
               OP_ADDHL: begin
                  sum  = {1'b0, rh, rl} + {1'b0, rb, rc};
                  half = {1'b0, rh[3:0], rl} + {1'b0, rb[3:0], rc};
                  rf = rf & 8'h80;
                  if (half[12]) rf = rf | 8'h20;
                  if (sum[16]) rf = rf | 8'h10;
                  {rh, rl} = sum[15:0];
                  cyc = 5'd8;
               end
               OP_LDABC: begin ra = mem_img[{rb, rc}]; cyc = 5'd8; end
               OP_DECBC: begin {rb, rc} = {rb, rc} - 16'd1; cyc = 5'd8; end
               OP_INCC:  begin rc = inc_flags(rc); cyc = 5'd4; end
               OP_DECC:  begin rc = dec_flags(rc); cyc = 5'd4; end
               OP_LDC:   begin rc = fetch_b(); cyc = 5'd8; end
               OP_RRCA: begin
                  rf = ra[0] ? 8'h10 : 8'h00;
                  ra = {ra[0], ra[7:1]};
                  cyc = 5'd4;
               end
               OP_JR: begin jump_rel(); cyc = 5'd12; end
               OP_JRNZ, OP_JRZ: begin
                  if (rf[7] == (op == OP_JRZ)) begin
                     jump_rel();
                     cyc = 5'd12;
                  end else begin
                     pc_q = pc_q + 16'd1;
                     cyc = 5'd8;
                  end
               end
               OP_LDHL:  begin {rh, rl} = fetch_w(); cyc = 5'd12; end
               OP_STHLD: begin
                  mem_put({rh, rl}, ra);
                  {rh, rl} = {rh, rl} - 16'd1;
                  cyc = 5'd8;
               end
               OP_LDA:   begin ra = fetch_b(); cyc = 5'd8; end
               OP_MOVBA: begin rb = ra; cyc = 5'd4; end
               OP_MOVLA: begin rl = ra; cyc = 5'd4; end
               OP_XORA:  begin ra = 8'h00; rf = 8'h80; cyc = 5'd4; end
               OP_JP:    begin pc_q = fetch_w(); cyc = 5'd16; end
               OP_CB: begin
                  b = fetch_b();
                  if (b == CB_RES0A) begin
                     ra = ra & 8'hFE;
                     cyc = 5'd8;
                  end else begin
                     bad = 1'b1;
                  end
               end
               OP_CALL: begin
                  a16 = fetch_w();
                  sp_q = sp_q - 16'd1;
                  mem_put(sp_q, pc_q[15:8]);
                  sp_q = sp_q - 16'd1;
                  mem_put(sp_q, pc_q[7:0]);
                  pc_q = a16;
                  cyc = 5'd24;
               end
               OP_STH:   begin b = fetch_b(); mem_put({8'hFF, b}, ra); cyc = 5'd12; end
               OP_STA16: begin a16 = fetch_w(); mem_put(a16, ra); cyc = 5'd16; end
               OP_LDH:   begin b = fetch_b(); ra = mem_img[{8'hFF, b}]; cyc = 5'd12; end
               OP_DI:    begin ime = 1'b0; cyc = 5'd4; end
               OP_LDA16: begin a16 = fetch_w(); ra = mem_img[a16]; cyc = 5'd16; end
               OP_CP: begin
                  v = fetch_b();
                  rf = 8'h40;
                  if (ra == v) rf = rf | 8'h80;
                  if (ra[3:0] < v[3:0]) rf = rf | 8'h20;
                  if (ra < v) rf = rf | 8'h10;
                  cyc = 5'd8;
               end
               default: bad = 1'b1;
            endcase
         end
         REQ_WRITE: mem_put(r.address, r.write_byte);
         REQ_READ:  rd = mem_img[r.address];
         default:   pc_q = r.address;
      endcase
      o.prog_counter      = pc_q;
      o.stack_ptr         = sp_q;
      o.reg_acc           = ra;
      o.reg_flags         = rf & 8'hF0;
      o.reg_bee           = rb;
      o.reg_cee           = rc;
      o.reg_high          = rh;
      o.reg_low           = rl;
      o.irq_master_enable = ime;
      o.cycles_taken      = cyc;
      o.read_byte         = rd;
      o.unimplemented     = bad;
      return o;
   endfunction

   function automatic req_type mk_req(req_kind_type k, logic [15:0] a, logic [7:0] d);
      req_type r;
      r.req_type   = k;
      r.address    = a;
      r.write_byte = d;
      return r;
   endfunction

   // Drives one transaction with random sender gaps and waits until it is taken.
   task automatic send_item(req_type r, bit typed, rsp_type want);
      rsp_type e;
      e = core_step(r);
      if (typed) e = want;
      pending_rsp.push_back(e);
      items_sent++;
      @(negedge clock);
      while ($urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_plain(req_kind_type k, logic [15:0] a, logic [7:0] d);
      send_item(mk_req(k, a, d), 1'b0, '0);
   endtask

   // One instruction: its bytes are stored at PC (if all are already written, only most of the time),
   // any data byte it loads is stored if not yet written, and then it is executed.
   task automatic run_instr();
      logic [15:0] pc0, da;
      logic [7:0]  ib [0:2];
      logic [7:0]  o;
      bit          need;
      int          k;
      pc0 = pc_q;
      ib[0] = ($urandom_range(99) < 85) ? op_list[$urandom_range(33)] : 8'($urandom);
      ib[1] = 8'($urandom);
      ib[2] = 8'($urandom);
      if (ib[0] == OP_CB && $urandom_range(99) < 70) ib[1] = CB_RES0A;
      if (!(mem_set[pc0] && mem_set[pc0 + 16'd1] && mem_set[pc0 + 16'd2]) ||
          $urandom_range(4) != 0) begin
         for (k = 0; k < 3; k++) send_plain(REQ_WRITE, pc0 + 16'(k), ib[k]);
      end
      o = mem_img[pc0];
      need = 1'b1;
      case (o)
         OP_LDABC: da = {rb, rc};
         OP_LDH:   da = {8'hFF, mem_img[pc0 + 16'd1]};
         OP_LDA16: da = {mem_img[pc0 + 16'd2], mem_img[pc0 + 16'd1]};
         default:  begin need = 1'b0; da = '0; end
      endcase
      if (need && !mem_set[da]) send_plain(REQ_WRITE, da, 8'($urandom));
      send_plain(REQ_EXEC, '0, '0);
   endtask

   // Random phase: mostly instructions, with host reads, writes and jumps mixed in.
   task automatic run_phase(int unsigned target);
      int unsigned stop_at;
      int unsigned pick;
      stop_at = items_sent + target;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            run_instr();
         end else if (pick < 80) begin
            send_plain(REQ_WRITE, ($urandom_range(1) != 0) ? 16'($urandom) :
                       {8'hFF, 8'($urandom)}, 8'($urandom));
         end else if (pick < 92) begin
            send_plain(REQ_READ, wr_list[$urandom_range(wr_list.size() - 1)], 8'($urandom));
         end else begin
            send_plain(REQ_SETPC, 16'($urandom), 8'($urandom));
         end
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Receiver stall pattern.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_pct);
   end

   // Result checker.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) $display("unexpected result transaction: %h", rsp_data);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.prog_counter !== want.prog_counter ||
                rsp_data.stack_ptr !== want.stack_ptr ||
                rsp_data.reg_acc !== want.reg_acc ||
                rsp_data.reg_flags !== want.reg_flags ||
                rsp_data.reg_bee !== want.reg_bee ||
                rsp_data.reg_cee !== want.reg_cee ||
                rsp_data.reg_high !== want.reg_high ||
                rsp_data.reg_low !== want.reg_low ||
                rsp_data.irq_master_enable !== want.irq_master_enable ||
                rsp_data.cycles_taken !== want.cycles_taken ||
                rsp_data.read_byte !== want.read_byte ||
                rsp_data.unimplemented !== want.unimplemented) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("mismatch: expected %h got %h", want, rsp_data);
            end
         end
      end
   end

   initial begin
      stim_row_type rows [$];
      stim_row_type row;
      rsp_type      zero_rsp;
      int           i;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      reset     = 1'b1;
      mismatch_cnt = 0;
      items_sent   = 0;
      send_pct = 6;
      recv_pct = 50;
      pc_q = 16'h0100;
      sp_q = 16'hFFFE;
      {ra, rf, rb, rc, rh, rl} = '0;
      ime = 1'b1;
      for (i = 0; i < 65536; i++) begin
         mem_set[i] = 1'b0;
         mem_img[i] = 8'h00;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table: state after reset, NOP, INC B wrapping to zero, an
      // unimplemented opcode, RES 0,A, the top address, PC wrap, DI and RRCA.
      zero_rsp = rsp_type'{16'h0100, 16'hFFFE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                           1'b1, 5'd0, 8'h00, 1'b0};
      row = '{mk_req(REQ_WRITE, 16'h0100, OP_NOP), 1'b1, zero_rsp};
      rows.push_back(row);
      zero_rsp.prog_counter = 16'h0101;
      zero_rsp.cycles_taken = 5'd4;
      row = '{mk_req(REQ_EXEC, 16'h0000, 8'h00), 1'b1, zero_rsp};
      rows.push_back(row);
      row.typed = 1'b0;
      row.r = mk_req(REQ_WRITE, 16'h0101, OP_LDB);    rows.push_back(row);
      row.r = mk_req(REQ_WRITE, 16'h0102, 8'hFF);     rows.push_back(row);
      row.r = mk_req(REQ_EXEC, 16'h0000, 8'h00);      rows.push_back(row);
      row.r = mk_req(REQ_WRITE, 16'h0103, OP_INCB);   rows.push_back(row);
      row.r = mk_req(REQ_EXEC, 16'h0000, 8'h00);      rows.push_back(row);
      row.r = mk_req(REQ_WRITE, 16'h0104, 8'hD3);     rows.push_back(row);
      row.r = mk_req(REQ_EXEC, 16'h0000, 8'h00);      rows.push_back(row);
      row.r = mk_req(REQ_WRITE, 16'h0105, OP_CB);     rows.push_back(row);
      row.r = mk_req(REQ_WRITE, 16'h0106, CB_RES0A);  rows.push_back(row);
      row.r = mk_req(REQ_EXEC, 16'h0000, 8'h00);      rows.push_back(row);
      row.r = mk_req(REQ_WRITE, 16'hFFFF, 8'hAA);     rows.push_back(row);
      row.r = mk_req(REQ_READ, 16'hFFFF, 8'h00);      rows.push_back(row);
      row.r = mk_req(REQ_SETPC, 16'hFFFF, 8'hFF);     rows.push_back(row);
      row.r = mk_req(REQ_EXEC, 16'hFFFF, 8'hFF);      rows.push_back(row);
      row.r = mk_req(REQ_WRITE, 16'h0000, OP_DI);     rows.push_back(row);
      row.r = mk_req(REQ_EXEC, 16'h0000, 8'h00);      rows.push_back(row);
      row.r = mk_req(REQ_WRITE, 16'h0001, OP_RRCA);   rows.push_back(row);
      row.r = mk_req(REQ_EXEC, 16'h0000, 8'h00);      rows.push_back(row);
      foreach (rows[i]) send_item(rows[i].r, rows[i].typed, rows[i].want);

      run_phase(230);
      // Hold the sender until every outstanding result has come back.
      drain();
      send_pct = 50;
      recv_pct = 6;
      run_phase(230);
      send_pct = 0;
      recv_pct = 0;
      run_phase(230);
      drain();

      if (mismatch_cnt == 0 && pending_rsp.size() == 0) begin
         $display("tb_sm83_instruction_subset_core OK");
      end else begin
         $display("tb_sm83_instruction_subset_core NOT OK");
      end
      $finish;
   end

   initial begin
      #3ms;
      $display("tb_sm83_instruction_subset_core NOT OK");
      $finish;
   end

endmodule
